### hdl/chkv_pkg.sv
package chkv_pkg;

   localparam logic [2:0] ACT_ADD     = 3'd0;
   localparam logic [2:0] ACT_SET     = 3'd1;
   localparam logic [2:0] ACT_REPLACE = 3'd2;
   localparam logic [2:0] ACT_GET     = 3'd3;
   localparam logic [2:0] ACT_REMOVE  = 3'd4;
   localparam logic [2:0] ACT_CLEAR   = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EXISTS  = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic       load;
      logic       mix;
      logic       rem_step;
      logic       head_rd;
      logic       head_take;
      logic       node_rd;
      logic       advance;
      logic       write_value;
      logic       unlink;
      logic       alloc_rd;
      logic       insert;
      logic       insert_fresh;
      logic       sweep;
      logic       clear_counts;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic       rsp_found;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       rem_done;
      logic       sweep_done;
      logic       cur_nil;
      logic       key_match;
      logic       pool_full;
      logic       free_empty;
   } dp_stat_type;

   function automatic logic [31:0] mix32(input logic [31:0] k);
      logic [31:0] h;
      h = k;
      h = h + ~(h << 15);
      h = h ^ (h >> 10);
      h = h + (h << 3);
      h = h ^ (h >> 6);
      h = h + ~(h << 11);
      h = h ^ (h >> 16);
      return h;
   endfunction

endpackage

### hdl/chained_hash_key_value_table.sv
// Key-value table with 32-bit keys and values, chained buckets over a node pool.
// Request channel (req_): tuser carries the action, tdata carries key and value.
// Response channel (rsp_): one response per request; tuser carries the status,
// tdata carries the found value and the entry count after the action.
// One request is in work at a time. From accept to response valid it runs
//   the hash mix, the remainder, the bucket head read, a read and a compare
//   per chain node visited and the response load, plus the end-of-chain
//   check on a miss and the linking of a new node. The remainder uses a
//   reciprocal multiply unless BUCKETS is a power of two.
// The chain walk sets the rate: each node costs one registered memory read
// and one key compare. The next request is taken at the earliest in the
// cycle after the response is loaded.
// Clear sweeps every bucket head to empty.
// Unused action codes go straight to the response without touching the table.
// After reset the same sweep runs with req_tready low.
// The response sits in an output register; a new request may be accepted
// while it waits, and the next response is held back until rsp_tready takes
// the previous one.
module chained_hash_key_value_table
   import chkv_pkg::*;
#(
   parameter int BUCKETS = 16,
   parameter int NODES   = 256
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   input  logic [63:0]                                  req_tdata,  // key, value
   input  logic [2:0]                                   req_tuser,  // action
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   output logic [((32 + $clog2(NODES + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
                                                       // found_value, entry_count
   output logic [1:0]                                   rsp_tuser   // status
);

   localparam int CW = $clog2(NODES + 1);
   localparam int DW = ((32 + CW + 7) / 8) * 8;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [31:0]   found;
   logic [CW-1:0] count;

   chkv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   chkv_dp #(
      .BUCKETS (BUCKETS),
      .NODES   (NODES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_action (req_tuser),
      .req_key    (req_tdata[31:0]),
      .req_value  (req_tdata[63:32]),
      .rsp_status (rsp_tuser),
      .rsp_found  (found),
      .rsp_count  (count)
   );

   assign rsp_tdata = DW'({count, found});

endmodule

### hdl/chkv_dp.sv
module chkv_dp
   import chkv_pkg::*;
#(
   parameter int BUCKETS = 16,
   parameter int NODES   = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dp_cmd_type                       cmd,
   output dp_stat_type                      stat,
   input  logic [2:0]                       req_action,
   input  logic [31:0]                      req_key,
   input  logic [31:0]                      req_value,
   output logic [1:0]                       rsp_status,
   output logic [31:0]                      rsp_found,
   output logic [$clog2(NODES + 1) - 1:0]   rsp_count
);

   localparam int BW = $clog2(BUCKETS);
   localparam int NW = $clog2(NODES);
   localparam int PW = NW + 1;
   localparam int CW = $clog2(NODES + 1);
   localparam bit POW2 = ((1 << BW) == BUCKETS);
   localparam logic [PW-1:0] NIL = PW'(NODES);
   // hash / BUCKETS = (hash * MAGIC) >> SH for every 32-bit hash
   localparam int SH = 32 + BW;
   localparam logic [63:0] MAGIC = ((64'd1 << SH) / 64'(BUCKETS)) + 64'd1;
   localparam logic [15:0] MAG_LO = MAGIC[15:0];
   localparam logic [16:0] MAG_HI = MAGIC[32:16];

   logic [2:0]    action_ff;
   logic [31:0]   key_ff;
   logic [31:0]   value_ff;
   logic [31:0]   hash_ff;
   logic [BW-1:0] rem_ff;
   logic [1:0]    rem_step_ff;
   logic [47:0]   prod_lo_ff;
   logic [48:0]   prod_hi_ff;
   logic [65:0]   prod_sum;
   logic [31:0]   quot_ff;
   logic [BW-1:0] bucket;
   logic [BW-1:0] sweep_cnt_ff;
   logic          sweep_done;

   logic [PW-1:0] head_mem [BUCKETS];
   logic [PW-1:0] head_q;
   logic [PW-1:0] head_ff;
   logic [PW-1:0] cur_ff;
   logic [PW-1:0] prev_ff;
   logic          prev_nil;

   logic [31:0]   node_key_mem  [NODES];
   logic [31:0]   node_val_mem  [NODES];
   logic [PW-1:0] node_next_mem [NODES];
   logic [31:0]   node_key_q;
   logic [31:0]   node_val_q;
   logic [PW-1:0] node_next_q;

   logic [NW-1:0] free_mem [NODES];
   logic [NW-1:0] free_q;
   logic [PW-1:0] free_top_ff;
   logic [PW-1:0] free_top_dec;
   logic [PW-1:0] fresh_ff;
   logic [PW-1:0] count_ff;

   logic [NW-1:0] new_node;
   logic [NW-1:0] node_waddr;
   logic          key_we;
   logic          val_we;
   logic          next_we;
   logic [PW-1:0] next_wdata;
   logic          head_we;
   logic [BW-1:0] head_waddr;
   logic [PW-1:0] head_wdata;

   logic [1:0]    rsp_status_ff;
   logic [31:0]   rsp_found_ff;
   logic [PW-1:0] rsp_count_ff;

   assign prod_sum   = {1'b0, prod_hi_ff, 16'd0} + {18'd0, prod_lo_ff};
   assign bucket     = POW2 ? hash_ff[BW-1:0] : rem_ff;
   assign sweep_done = (sweep_cnt_ff == BW'(BUCKETS - 1));
   assign prev_nil   = (prev_ff == NIL);
   assign free_top_dec = free_top_ff - PW'(1);
   assign new_node   = cmd.insert_fresh ? fresh_ff[NW-1:0] : free_q;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         key_ff    <= req_key;
         value_ff  <= req_value;
      end
      if (cmd.mix) begin
         hash_ff <= mix32(key_ff);
      end else if (cmd.rem_step) begin
         // multiply by the reciprocal, shift, then take back quotient * BUCKETS
         case (rem_step_ff)
            2'd0: begin
               prod_lo_ff <= 48'(hash_ff) * 48'(MAG_LO);
               prod_hi_ff <= 49'(hash_ff) * 49'(MAG_HI);
            end
            2'd1: quot_ff <= 32'(prod_sum >> SH);
            default: rem_ff <= hash_ff[BW-1:0] - BW'(quot_ff[BW-1:0] * BW'(BUCKETS));
         endcase
      end
      if (cmd.head_take) begin
         head_ff <= head_q;
         cur_ff  <= head_q;
         prev_ff <= NIL;
      end else if (cmd.advance) begin
         prev_ff <= cur_ff;
         cur_ff  <= node_next_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_step_ff <= '0;
      end else if (cmd.mix) begin
         rem_step_ff <= '0;
      end else if (cmd.rem_step && rem_step_ff != 2'd2) begin
         rem_step_ff <= rem_step_ff + 2'd1;
      end
   end

   always_comb begin
      node_waddr = cur_ff[NW-1:0];
      if (cmd.insert) begin
         node_waddr = new_node;
      end else if (cmd.unlink) begin
         node_waddr = prev_ff[NW-1:0];
      end
      key_we     = cmd.insert;
      val_we     = cmd.insert || cmd.write_value;
      next_we    = cmd.insert || (cmd.unlink && !prev_nil);
      next_wdata = cmd.insert ? head_ff : node_next_q;
      head_we    = cmd.sweep || cmd.insert || (cmd.unlink && prev_nil);
      head_waddr = cmd.sweep ? sweep_cnt_ff : bucket;
      head_wdata = cmd.sweep ? NIL : (cmd.insert ? {1'b0, new_node} : node_next_q);
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         node_key_mem[node_waddr] <= key_ff;
      end
      if (val_we) begin
         node_val_mem[node_waddr] <= value_ff;
      end
      if (next_we) begin
         node_next_mem[node_waddr] <= next_wdata;
      end
      if (cmd.node_rd) begin
         node_key_q  <= node_key_mem[cur_ff[NW-1:0]];
         node_val_q  <= node_val_mem[cur_ff[NW-1:0]];
         node_next_q <= node_next_mem[cur_ff[NW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      if (cmd.head_rd) begin
         head_q <= head_mem[bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.unlink) begin
         free_mem[free_top_ff[NW-1:0]] <= cur_ff[NW-1:0];
      end
      if (cmd.alloc_rd) begin
         free_q <= free_mem[free_top_dec[NW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else if (cmd.sweep) begin
         sweep_cnt_ff <= sweep_done ? '0 : sweep_cnt_ff + BW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_counts) begin
         free_top_ff <= '0;
         fresh_ff    <= '0;
         count_ff    <= '0;
      end else begin
         if (cmd.unlink) begin
            free_top_ff <= free_top_ff + PW'(1);
            count_ff    <= count_ff - PW'(1);
         end else if (cmd.insert) begin
            count_ff <= count_ff + PW'(1);
            if (cmd.insert_fresh) begin
               fresh_ff <= fresh_ff + PW'(1);
            end
         end
         if (cmd.alloc_rd) begin
            free_top_ff <= free_top_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_found_ff  <= cmd.rsp_found ? node_val_q : 32'd0;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_count  = rsp_count_ff[CW-1:0];

   always_comb begin
      stat.action     = action_ff;
      stat.rem_done   = POW2 || (rem_step_ff == 2'd2);
      stat.sweep_done = sweep_done;
      stat.cur_nil    = (cur_ff == NIL);
      stat.key_match  = (node_key_q == key_ff);
      stat.pool_full  = (count_ff == PW'(NODES));
      stat.free_empty = (free_top_ff == '0);
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PW'(NODES))
      else $error("stored count above pool size");
   // a popped node is in flight between the free stack read and its insert
   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, free_top_ff} + {1'b0, count_ff} + (PW+1)'(cmd.insert && !cmd.insert_fresh))
         == {1'b0, fresh_ff})
      else $error("free stack and stored count do not add up to nodes handed out");
   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(cmd.unlink && (cmd.alloc_rd || cmd.insert)))
      else $error("free stack push and pop in one cycle");
`endif

endmodule

### hdl/chkv_ctrl.sv
module chkv_ctrl
   import chkv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [11:0] {
      S_INIT   = 12'b0000_0000_0001,
      S_IDLE   = 12'b0000_0000_0010,
      S_MIX    = 12'b0000_0000_0100,
      S_REM    = 12'b0000_0000_1000,
      S_HEAD   = 12'b0000_0001_0000,
      S_HTAKE  = 12'b0000_0010_0000,
      S_WALK   = 12'b0000_0100_0000,
      S_NCHK   = 12'b0000_1000_0000,
      S_ALLOC  = 12'b0001_0000_0000,
      S_INSERT = 12'b0010_0000_0000,
      S_CLEAR  = 12'b0100_0000_0000,
      S_RESP   = 12'b1000_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       found_ff, found_in;
   logic       fresh_ff, fresh_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      found_in  = found_ff;
      fresh_in  = fresh_ff;
      cmd       = '0;
      cmd.rsp_status = status_ff;
      cmd.rsp_found  = found_ff;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep        = 1'b1;
            cmd.clear_counts = 1'b1;
            if (stat.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load  = 1'b1;
               status_in = ST_OK;
               found_in  = 1'b0;
               state_in  = S_MIX;
            end
         end
         S_MIX: begin
            if (stat.action == ACT_CLEAR) begin
               state_in = S_CLEAR;
            end else if (stat.action > ACT_CLEAR) begin
               state_in = S_RESP;
            end else begin
               cmd.mix  = 1'b1;
               state_in = S_REM;
            end
         end
         S_REM: begin
            cmd.rem_step = 1'b1;
            if (stat.rem_done) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in    = S_HTAKE;
         end
         S_HTAKE: begin
            cmd.head_take = 1'b1;
            state_in      = S_WALK;
         end
         S_WALK: begin
            if (!stat.cur_nil) begin
               cmd.node_rd = 1'b1;
               state_in    = S_NCHK;
            end else if (stat.action == ACT_ADD || stat.action == ACT_SET) begin
               fresh_in = stat.free_empty;
               if (stat.pool_full) begin
                  status_in = ST_FULL;
                  state_in  = S_RESP;
               end else if (stat.free_empty) begin
                  state_in = S_INSERT;
               end else begin
                  state_in = S_ALLOC;
               end
            end else begin
               status_in = ST_MISSING;
               state_in  = S_RESP;
            end
         end
         S_NCHK: begin
            if (!stat.key_match) begin
               cmd.advance = 1'b1;
               state_in    = S_WALK;
            end else begin
               state_in = S_RESP;
               unique case (stat.action) inside
                  ACT_ADD: status_in = ST_EXISTS;
                  ACT_SET, ACT_REPLACE: cmd.write_value = 1'b1;
                  ACT_GET: found_in = 1'b1;
                  ACT_REMOVE: begin
                     cmd.unlink = 1'b1;
                     found_in   = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_ALLOC: begin
            cmd.alloc_rd = 1'b1;
            state_in     = S_INSERT;
         end
         S_INSERT: begin
            cmd.insert       = 1'b1;
            cmd.insert_fresh = fresh_ff;
            state_in         = S_RESP;
         end
         S_CLEAR: begin
            cmd.sweep        = 1'b1;
            cmd.clear_counts = 1'b1;
            if (stat.sweep_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_OK;
         found_ff     <= 1'b0;
         fresh_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         found_ff     <= found_in;
         fresh_ff     <= fresh_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("request accepted but controller stayed idle");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> slot_free)
      else $error("response register overwritten while stalled");
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.rsp_load))
      else $error("response valid without a load");
`endif

endmodule

### bench/chained_hash_key_value_table_test.sv
`timescale 1ns / 100ps

module chained_hash_key_value_table_test;
   import chkv_pkg::*;

   localparam int BUCKETS = 16;
   localparam int NODES   = 256;
   localparam int NIL     = NODES;

   // codes the block ignores
   localparam logic [2:0] ACT_SPARE6 = 3'd6;
   localparam logic [2:0] ACT_SPARE7 = 3'd7;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] found;
      logic [8:0]  count;
   } lookup_result_type;

   typedef struct {
      logic [2:0]        action;
      logic [31:0]       key;
      logic [31:0]       value;
      bit                typed;
      lookup_result_type want;
   } request_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // key, value
   logic [2:0]  req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // found_value, entry_count
   logic [1:0]  rsp_tuser;   // status

   chained_hash_key_value_table #(.BUCKETS(BUCKETS), .NODES(NODES)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // table shadow
   int chain_head [BUCKETS];
   logic [31:0] slot_key [NODES];
   logic [31:0] slot_value [NODES];
   int slot_next [NODES];
   int free_slots [NODES];
   int free_left;
   int entries;

   lookup_result_type pending_q [$];
   int  errors;
   int  mismatches;
   bit  quiet;

   function automatic logic [31:0] wang_mix(input logic [31:0] k);
      logic [31:0] x;
      x = k;
      x = x + ~(x << 15);
      x = x ^ (x >> 10);
      x = x + (x << 3);
      x = x ^ (x >> 6);
      x = x + ~(x << 11);
      x = x ^ (x >> 16);
      return x;
   endfunction

   function automatic void empty_shadow();
      for (int i = 0; i < BUCKETS; i++) chain_head[i] = NIL;
      for (int i = 0; i < NODES; i++) free_slots[i] = i;
      free_left = NODES;
      entries = 0;
   endfunction

   function automatic logic [1:0] link_new(int b, logic [31:0] key, logic [31:0] value);
      int n;
      if (free_left == 0) return ST_FULL;
      free_left--;
      n = free_slots[free_left];
      slot_key[n] = key;
      slot_value[n] = value;
      slot_next[n] = chain_head[b];
      chain_head[b] = n;
      entries++;
      return ST_OK;
   endfunction

   function automatic lookup_result_type table_apply(logic [2:0] action, logic [31:0] key,
                                                     logic [31:0] value);
      lookup_result_type r;
      logic [31:0] h;
      int b, p, q, node, prev;
      r.status = ST_OK;
      r.found = '0;
      h = wang_mix(key);
      b = int'(h[3:0]);
      node = NIL;
      prev = NIL;
      p = chain_head[b];
      q = NIL;
      while (p != NIL) begin
         if (slot_key[p] == key) begin
            node = p;
            prev = q;
            break;
         end
         q = p;
         p = slot_next[p];
      end
      case (action)
         ACT_ADD: begin
            if (node != NIL) r.status = ST_EXISTS;
            else r.status = link_new(b, key, value);
         end
         ACT_SET: begin
            if (node != NIL) slot_value[node] = value;
            else r.status = link_new(b, key, value);
         end
         ACT_REPLACE: begin
            if (node != NIL) slot_value[node] = value;
            else r.status = ST_MISSING;
         end
         ACT_GET: begin
            if (node != NIL) r.found = slot_value[node];
            else r.status = ST_MISSING;
         end
         ACT_REMOVE: begin
            if (node != NIL) begin
               r.found = slot_value[node];
               if (prev != NIL) slot_next[prev] = slot_next[node];
               else chain_head[b] = slot_next[node];
               free_slots[free_left] = node;
               free_left++;
               entries--;
            end else begin
               r.status = ST_MISSING;
            end
         end
         ACT_CLEAR: empty_shadow();
         default: ;
      endcase
      r.count = entries[8:0];
      return r;
   endfunction

   task automatic send_request(request_row_type row);
      lookup_result_type r;
      req_tvalid <= 1'b1;
      req_tuser  <= row.action;
      req_tdata  <= {row.value, row.key};
      do @(posedge clock); while (!req_tready);
      r = table_apply(row.action, row.key, row.value);
      pending_q.push_back(row.typed ? row.want : r);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic send_plain(logic [2:0] a, logic [31:0] k, logic [31:0] v);
      request_row_type row;
      row.action = a;
      row.key = k;
      row.value = v;
      row.typed = 1'b0;
      row.want = '{ST_OK, 32'd0, 9'd0};
      send_request(row);
   endtask

   task automatic drain_pause();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [2:0] pick_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return ACT_CLEAR;
      if (r < 4) return (r == 2) ? ACT_SPARE6 : ACT_SPARE7;
      return 3'($urandom_range(0, 4));
   endfunction

   // response side stall bursts
   int hold;
   initial begin
      rsp_tready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (quiet) begin
            rsp_tready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            hold = $urandom_range(1, 12);
         end else begin
            rsp_tready <= 1'b1;
            hold = $urandom_range(1, 20);
         end
      end
   end

   always @(posedge clock) begin
      lookup_result_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) $display("unexpected response status=%0d", rsp_tuser);
         end else begin
            w = pending_q.pop_front();
            if (rsp_tuser !== w.status || rsp_tdata[31:0] !== w.found ||
                rsp_tdata[40:32] !== w.count) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected st=%0d val=%h cnt=%0d got st=%0d val=%h cnt=%0d",
                           w.status, w.found, w.count,
                           rsp_tuser, rsp_tdata[31:0], rsp_tdata[40:32]);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("chained_hash_key_value_table_test: FAIL");
      $finish;
   end

   initial begin
      request_row_type dir_rows [$];
      logic [31:0] key_pool [24];
      logic [31:0] filled [$];
      logic [31:0] k;
      errors = 0;
      mismatches = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_ADD;
      empty_shadow();
      for (int i = 0; i < NODES; i++) begin
         slot_key[i] = '0;
         slot_value[i] = '0;
         slot_next[i] = 0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      dir_rows.push_back('{ACT_GET,     32'h0, 32'h0, 1, '{ST_MISSING, 32'h0, 9'd0}});
      dir_rows.push_back('{ACT_REMOVE,  32'h0, 32'h0, 1, '{ST_MISSING, 32'h0, 9'd0}});
      dir_rows.push_back('{ACT_REPLACE, 32'h0, 32'h5, 1, '{ST_MISSING, 32'h0, 9'd0}});
      dir_rows.push_back('{ACT_ADD, 32'h0, 32'hFFFF_FFFF, 1, '{ST_OK, 32'h0, 9'd1}});
      dir_rows.push_back('{ACT_ADD,     32'h0, 32'h1, 1, '{ST_EXISTS, 32'h0, 9'd1}});
      dir_rows.push_back('{ACT_GET, 32'h0, 32'h0, 1, '{ST_OK, 32'hFFFF_FFFF, 9'd1}});
      dir_rows.push_back('{ACT_SET,     32'h0, 32'h0, 1, '{ST_OK, 32'h0, 9'd1}});
      dir_rows.push_back('{ACT_SET, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 1, '{ST_OK, 32'h0, 9'd2}});
      dir_rows.push_back('{ACT_REPLACE, 32'hFFFF_FFFF, 32'h1234_5678, 0, '{ST_OK, 32'h0, 9'd0}});
      dir_rows.push_back('{ACT_GET,     32'hFFFF_FFFF, 32'h0, 0, '{ST_OK, 32'h0, 9'd0}});
      dir_rows.push_back('{ACT_SPARE6,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{ST_OK, 32'h0, 9'd2}});
      dir_rows.push_back('{ACT_SPARE7,  32'h0, 32'h0, 1, '{ST_OK, 32'h0, 9'd2}});
      dir_rows.push_back('{ACT_REMOVE,  32'h0, 32'h0, 1, '{ST_OK, 32'h0, 9'd1}});
      dir_rows.push_back('{ACT_REMOVE,  32'hFFFF_FFFF, 32'h0, 0, '{ST_OK, 32'h0, 9'd0}});
      dir_rows.push_back('{ACT_ADD,     32'h8000_0001, 32'h7FFF_FFFF, 0, '{ST_OK, 32'h0, 9'd0}});
      dir_rows.push_back('{ACT_ADD,     32'h0000_0011, 32'h1, 0, '{ST_OK, 32'h0, 9'd0}});
      dir_rows.push_back('{ACT_CLEAR,   32'h0, 32'h0, 1, '{ST_OK, 32'h0, 9'd0}});
      dir_rows.push_back('{ACT_GET,     32'h8000_0001, 32'h0, 1, '{ST_MISSING, 32'h0, 9'd0}});
      foreach (dir_rows[i]) send_request(dir_rows[i]);

      for (int i = 0; i < 24; i++) key_pool[i] = (i < 12) ? i : $urandom;
      key_pool[12] = 32'hFFFF_FFFF;

      for (int i = 0; i < 500; i++)
         send_plain(pick_action(), key_pool[$urandom_range(0, 23)], $urandom);

      // fill the pool past its end
      drain_pause();
      send_plain(ACT_CLEAR, $urandom, $urandom);
      for (int i = 0; i < 270; i++) begin
         k = $urandom;
         filled.push_back(k);
         send_plain($urandom_range(0, 1) ? ACT_SET : ACT_ADD, k, $urandom);
      end
      for (int i = 0; i < 120; i++)
         send_plain(3'($urandom_range(1, 4)), filled[$urandom_range(0, filled.size() - 1)],
                    $urandom);

      drain_pause();
      for (int i = 0; i < 500; i++) begin
         if (i == 300) quiet = 1'b1;
         send_plain(pick_action(), key_pool[$urandom_range(0, 23)], $urandom);
      end

      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_q.size() == 0)
         $display("chained_hash_key_value_table_test: PASS");
      else
         $display("chained_hash_key_value_table_test: FAIL");
      $finish;
   end

endmodule

### chained_hash_key_value_table.f
hdl/chkv_pkg.sv
hdl/chkv_dp.sv
hdl/chkv_ctrl.sv
hdl/chained_hash_key_value_table.sv
bench/chained_hash_key_value_table_test.sv
